### hdl/pmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmq_pkg
// Shared types, sizes and helpers of the per-process mailbox queues.
// ----------------------------------------------------------------------------
package pmq_pkg;

    localparam int NUM_QUEUES  = 16;
    localparam int QUEUE_DEPTH = 8;

    localparam int QIDX_W = $clog2(NUM_QUEUES);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(NUM_QUEUES * QUEUE_DEPTH);
    localparam int NUM_ENTRIES = NUM_QUEUES * QUEUE_DEPTH;

    localparam int CMD_W   = 2;
    localparam int PID_W   = 8;
    localparam int SELF_W  = 4;
    localparam int WORD_W  = 32;
    localparam int PTYPE_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEND  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DEST = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_FETCH,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic [PTR_W-1:0]  head;
        logic [PTR_W-1:0]  tail;
        logic [FILL_W-1:0] fill;
    } ptr_entry_t;

    typedef struct packed {
        logic [WORD_W-1:0] tag;
        logic [WORD_W-1:0] subject;
    } subj_tag_t;

    typedef struct packed {
        logic [WORD_W-1:0]  value;
        logic [PTYPE_W-1:0] ptype;
        logic [SELF_W-1:0]  sender;
    } sender_payload_t;

    typedef struct packed {
        status_t            status;
        logic [SELF_W-1:0]  msg_to;
        logic [SELF_W-1:0]  msg_from;
        logic [WORD_W-1:0]  msg_subject;
        logic [WORD_W-1:0]  msg_tag;
        logic [PTYPE_W-1:0] msg_type;
        logic [WORD_W-1:0]  msg_value;
        logic               is_empty;
        logic               wake_valid;
        logic [SELF_W-1:0]  wake_pid;
    } result_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [QIDX_W-1:0] q,
                                                     input logic [PTR_W-1:0]  p);
        entry_addr = ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
    endfunction

endpackage

### hdl/pmq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmq_req_if
// Request channel of the mailbox queues: command and message fields.
// ----------------------------------------------------------------------------
interface pmq_req_if;
    import pmq_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [PID_W-1:0]   target_pid;
    logic [SELF_W-1:0]  current_pid;
    logic               dest_present;
    logic [WORD_W-1:0]  subject;
    logic [WORD_W-1:0]  tag;
    logic [PTYPE_W-1:0] payload_type;
    logic [WORD_W-1:0]  payload_value;

    modport source (
        output valid, command, target_pid, current_pid, dest_present,
               subject, tag, payload_type, payload_value,
        input  ready
    );

    modport sink (
        input  valid, command, target_pid, current_pid, dest_present,
               subject, tag, payload_type, payload_value,
        output ready
    );

endinterface

### hdl/pmq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmq_rsp_if
// Response channel of the mailbox queues: status and popped envelope.
// ----------------------------------------------------------------------------
interface pmq_rsp_if;
    import pmq_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [SELF_W-1:0]  msg_to;
    logic [SELF_W-1:0]  msg_from;
    logic [WORD_W-1:0]  msg_subject;
    logic [WORD_W-1:0]  msg_tag;
    logic [PTYPE_W-1:0] msg_type;
    logic [WORD_W-1:0]  msg_value;
    logic               is_empty;
    logic               wake_valid;
    logic [SELF_W-1:0]  wake_pid;

    modport source (
        output valid, status, msg_to, msg_from, msg_subject, msg_tag,
               msg_type, msg_value, is_empty, wake_valid, wake_pid,
        input  ready
    );

    modport sink (
        input  valid, status, msg_to, msg_from, msg_subject, msg_tag,
               msg_type, msg_value, is_empty, wake_valid, wake_pid,
        output ready
    );

endinterface

### hdl/per_process_mailbox_queues_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_process_mailbox_queues_top
// Bank of ring mailboxes, one per process slot, with send, read and empty
// query requests.
//
// Usage: a request enters on req (valid/ready); exactly one response leaves
// on rsp (valid/ready) for each request, in request order.
// Send, empty query and failed read are decoded in S_LOOKUP from the
// pointer memory read and go to the output register; a successful read
// also passes S_FETCH, since the pointer memory read is followed by the
// envelope memory read. Each request ends its read-modify-write of the
// per-mailbox pointer memory before the next request is taken.
// Only one request is in flight; req.ready is high while the block is idle.
// The response sits in an output register, so a new request is taken while
// a finished response still waits; if the receiver stalls, the next result
// is parked until the output register frees.
// Reset: all mailboxes become empty at once (per-mailbox valid bits), no
// clearing pass; the envelope memory is not cleared.
// ----------------------------------------------------------------------------
module per_process_mailbox_queues_top (
    input  logic      clk,
    input  logic      rst_n,
    pmq_req_if.sink   req,
    pmq_rsp_if.source rsp
);
    import pmq_pkg::*;

    // memories
    ptr_entry_t      ptr_mem [NUM_QUEUES];
    subj_tag_t       entry_subject_tag [NUM_ENTRIES];
    sender_payload_t entry_sender_payload [NUM_ENTRIES];

    logic [NUM_QUEUES-1:0] ptr_valid_reg;
    ptr_entry_t            ptr_rdata_reg;
    logic                  ptr_rvalid_reg;
    subj_tag_t             st_rdata_reg;
    sender_payload_t       sp_rdata_reg;

    state_t state_reg, state_next;

    // request registers
    cmd_t               cmd_reg;
    logic [QIDX_W-1:0]  qidx_reg;
    logic [PID_W-1:0]   target_reg;
    logic [SELF_W-1:0]  self_reg;
    logic               in_range_reg;
    logic               self_ok_reg;
    logic               present_reg;
    logic [WORD_W-1:0]  subject_reg;
    logic [WORD_W-1:0]  tag_reg;
    logic [PTYPE_W-1:0] ptype_reg;
    logic [WORD_W-1:0]  pvalue_reg;

    result_t res_reg;
    result_t out_reg;
    logic    out_valid_reg;

    logic              accept;
    logic [QIDX_W-1:0] in_qidx;
    logic              out_free;
    ptr_entry_t        ptr_cur;
    logic              send_ok;
    logic              read_ok;
    result_t           lookup_res;
    result_t           res_now;
    logic              load_out;
    logic              save_res;
    logic              ptr_we;
    ptr_entry_t        ptr_wdata;
    logic              ent_we;
    logic              ent_re;
    logic [ADDR_W-1:0] ent_addr;

    assign accept   = req.valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;
    assign in_qidx  = (cmd_t'(req.command) == CMD_READ) ? QIDX_W'(req.current_pid)
                                                        : QIDX_W'(req.target_pid);
    assign ptr_cur  = ptr_rvalid_reg ? ptr_rdata_reg : '0;

    // lookup decode
    always_comb
    begin
        lookup_res = '0;
        send_ok    = 1'b0;
        read_ok    = 1'b0;
        ptr_wdata  = ptr_cur;
        ent_addr   = entry_addr(qidx_reg, ptr_cur.tail);
        unique case (cmd_reg)
            CMD_SEND:
            begin
                if (!in_range_reg || !present_reg)
                begin
                    lookup_res.status = ST_BAD_DEST;
                end
                else if (ptr_cur.fill == FILL_W'(QUEUE_DEPTH))
                begin
                    lookup_res.status = ST_FULL;
                end
                else
                begin
                    send_ok               = 1'b1;
                    lookup_res.wake_valid = 1'b1;
                    lookup_res.wake_pid   = target_reg[SELF_W-1:0];
                    ptr_wdata.tail        = ring_next(ptr_cur.tail);
                    ptr_wdata.fill        = ptr_cur.fill + 1'b1;
                end
            end
            CMD_READ:
            begin
                ent_addr = entry_addr(qidx_reg, ptr_cur.head);
                if (!self_ok_reg || ptr_cur.fill == '0)
                begin
                    lookup_res.status = ST_EMPTY;
                end
                else
                begin
                    read_ok           = 1'b1;
                    lookup_res.msg_to = self_reg;
                    ptr_wdata.head    = ring_next(ptr_cur.head);
                    ptr_wdata.fill    = ptr_cur.fill - 1'b1;
                end
            end
            CMD_QUERY:
            begin
                lookup_res.is_empty = !in_range_reg || (ptr_cur.fill == '0);
            end
            default:
            begin
                lookup_res = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (read_ok)
                begin
                    state_next = S_FETCH;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_HOLD;
                end
            end
            S_FETCH:
            begin
                state_next = out_free ? S_IDLE : S_HOLD;
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        res_now  = res_reg;
        load_out = 1'b0;
        save_res = 1'b0;
        ptr_we   = 1'b0;
        ent_we   = 1'b0;
        ent_re   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                res_now = res_reg;
            end
            S_LOOKUP:
            begin
                res_now  = lookup_res;
                ptr_we   = send_ok || read_ok;
                ent_we   = send_ok;
                ent_re   = read_ok;
                load_out = !read_ok && out_free;
                save_res = read_ok || !out_free;
            end
            S_FETCH:
            begin
                res_now.msg_from    = sp_rdata_reg.sender;
                res_now.msg_subject = st_rdata_reg.subject;
                res_now.msg_tag     = st_rdata_reg.tag;
                res_now.msg_type    = sp_rdata_reg.ptype;
                res_now.msg_value   = sp_rdata_reg.value;
                load_out            = out_free;
                save_res            = !out_free;
            end
            S_HOLD:
            begin
                load_out = out_free;
            end
            default:
            begin
                res_now = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ptr_valid_reg  <= '0;
            ptr_rvalid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ptr_we)
            begin
                ptr_valid_reg[qidx_reg] <= 1'b1;
            end
            if (accept)
            begin
                ptr_rvalid_reg <= ptr_valid_reg[in_qidx];
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // pointer memory
    always_ff @(posedge clk)
    begin
        if (ptr_we)
        begin
            ptr_mem[qidx_reg] <= ptr_wdata;
        end
        if (accept)
        begin
            ptr_rdata_reg <= ptr_mem[in_qidx];
        end
    end

    // envelope memories
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_subject_tag[ent_addr]    <= '{tag: tag_reg, subject: subject_reg};
            entry_sender_payload[ent_addr] <= '{value: pvalue_reg, ptype: ptype_reg,
                                                sender: self_reg};
        end
        if (ent_re)
        begin
            st_rdata_reg <= entry_subject_tag[ent_addr];
            sp_rdata_reg <= entry_sender_payload[ent_addr];
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= cmd_t'(req.command);
            qidx_reg     <= in_qidx;
            target_reg   <= req.target_pid;
            self_reg     <= req.current_pid;
            in_range_reg <= (32'(req.target_pid) < NUM_QUEUES);
            self_ok_reg  <= (32'(req.current_pid) < NUM_QUEUES);
            present_reg  <= req.dest_present;
            subject_reg  <= req.subject;
            tag_reg      <= req.tag;
            ptype_reg    <= req.payload_type;
            pvalue_reg   <= req.payload_value;
        end
        if (save_res)
        begin
            res_reg <= res_now;
        end
        if (load_out)
        begin
            out_reg <= res_now;
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.msg_to      = out_reg.msg_to;
    assign rsp.msg_from    = out_reg.msg_from;
    assign rsp.msg_subject = out_reg.msg_subject;
    assign rsp.msg_tag     = out_reg.msg_tag;
    assign rsp.msg_type    = out_reg.msg_type;
    assign rsp.msg_value   = out_reg.msg_value;
    assign rsp.is_empty    = out_reg.is_empty;
    assign rsp.wake_valid  = out_reg.wake_valid;
    assign rsp.wake_pid    = out_reg.wake_pid;

endmodule
